// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the dot plotting pipeline
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pprp_pkg.sv
// ----------------------------------------------------------------------------
// pprp_pkg
// types and constants shared by the point rotate, project and plot pipeline
// ----------------------------------------------------------------------------
package pprp_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int COORD_W    = 16;
   localparam int SIN_W      = 14;
   localparam int DIM_W      = 10;
   localparam int COLOR_W    = 8;
   localparam int NIB_W      = 4;
   localparam int PIX_W      = 16;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int PROD_W     = COORD_W + SIN_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int SCALE_DIV  = 25;
   localparam int SIZE_BASE  = 3;
   localparam int DEPTH_SH   = 2;
   localparam int DOT_PIXELS = 4;
   localparam int DOT_CNT_W  = $clog2(DOT_PIXELS);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SIN_W;
   localparam int ISSUE_GAP  = DOT_PIXELS - 1;
   localparam int GAP_W      = $clog2(DOT_PIXELS);

   localparam logic [NIB_W-1:0]        ALPHA       = 4'hF;
   localparam logic signed [SIN_W-1:0] RST_SINE    = 14'sd0;
   localparam logic signed [SIN_W-1:0] RST_COSINE  = 14'sd4096;
   localparam logic [DIM_W-1:0]        RST_WIDTH   = 10'd480;
   localparam logic [DIM_W-1:0]        RST_HEIGHT  = 10'd272;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT1_SINE     = 3'd0,
      CSR_ROT1_COSINE   = 3'd1,
      CSR_ROT2_SINE     = 3'd2,
      CSR_ROT2_COSINE   = 3'd3,
      CSR_ROT3_SINE     = 3'd4,
      CSR_ROT3_COSINE   = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic signed [COORD_W-1:0] z_coord;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
   } point_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
      logic [PIX_W-1:0] pixel_color;
      logic             last_pixel;
   } pixel_type;

   typedef struct packed {
      logic signed [SIN_W-1:0] rot1_sine;
      logic signed [SIN_W-1:0] rot1_cosine;
      logic signed [SIN_W-1:0] rot2_sine;
      logic signed [SIN_W-1:0] rot2_cosine;
      logic signed [SIN_W-1:0] rot3_sine;
      logic signed [SIN_W-1:0] rot3_cosine;
      logic [DIM_W-1:0]        screen_width;
      logic [DIM_W-1:0]        screen_height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic signed [COORD_W-1:0] z_coord;
      logic [PIX_W-1:0]          color;
   } rot_type;

   typedef struct packed {
      logic [PIX_W-1:0] pos_x;
      logic [PIX_W-1:0] pos_y;
      logic [PIX_W-1:0] color;
   } dot_type;

endpackage

// File: design/pprp_rotator.sv
// ----------------------------------------------------------------------------
// pprp_rotator
// four-stage pipeline of three planar rotations in fixed point
// ----------------------------------------------------------------------------
module pprp_rotator import pprp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  point_type in_point,
   input  cfg_type   cfg,
   output logic      out_valid,
   output rot_type   out_rot
);

   localparam int NSTAGE = 4;

   typedef struct packed {
      logic signed [PROD_W-1:0] a_cos;
      logic signed [PROD_W-1:0] b_sin;
      logic signed [PROD_W-1:0] a_sin;
      logic signed [PROD_W-1:0] b_cos;
   } prod_type;

   function automatic prod_type products(input logic signed [COORD_W-1:0] a,
                                         input logic signed [COORD_W-1:0] b,
                                         input logic signed [SIN_W-1:0] s,
                                         input logic signed [SIN_W-1:0] c);
      prod_type p;
      p.a_cos = PROD_W'(a) * PROD_W'(c);
      p.b_sin = PROD_W'(b) * PROD_W'(s);
      p.a_sin = PROD_W'(a) * PROD_W'(s);
      p.b_cos = PROD_W'(b) * PROD_W'(c);
      return p;
   endfunction

   // divide by one in fixed point toward zero, keep the low coordinate bits
   function automatic logic signed [COORD_W-1:0] frac_trunc(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v[SUM_W-1] ? v + SUM_W'(ONE - 1) : v;
      return t[FRAC_BITS +: COORD_W];
   endfunction

   function automatic logic signed [COORD_W-1:0] turn_a(input prod_type p);
      return frac_trunc(SUM_W'(p.a_cos) - SUM_W'(p.b_sin));
   endfunction

   function automatic logic signed [COORD_W-1:0] turn_b(input prod_type p);
      return frac_trunc(SUM_W'(p.a_sin) + SUM_W'(p.b_cos));
   endfunction

   logic [NSTAGE-1:0]         valid_ff, valid_in;
   prod_type                  s1_prod_ff, s1_prod_in;
   logic signed [COORD_W-1:0] s1_y_ff, s1_y_in;
   logic [PIX_W-1:0]          s1_color_ff, s1_color_in;
   prod_type                  s2_prod_ff, s2_prod_in;
   logic signed [COORD_W-1:0] s2_x_ff, s2_x_in;
   logic [PIX_W-1:0]          s2_color_ff;
   prod_type                  s3_prod_ff, s3_prod_in;
   logic signed [COORD_W-1:0] s3_z_ff, s3_z_in;
   logic [PIX_W-1:0]          s3_color_ff;
   rot_type                   s4_rot_ff, s4_rot_in;

   always_comb begin
      valid_in    = {valid_ff[NSTAGE-2:0], in_valid};
      s1_prod_in  = products(in_point.x_coord, in_point.z_coord,
                             cfg.rot1_sine, cfg.rot1_cosine);
      s1_y_in     = in_point.y_coord;
      s1_color_in = {ALPHA, in_point.red[COLOR_W-1 -: NIB_W],
                     in_point.green[COLOR_W-1 -: NIB_W], in_point.blue[COLOR_W-1 -: NIB_W]};
      s2_x_in     = turn_a(s1_prod_ff);
      s2_prod_in  = products(s1_y_ff, turn_b(s1_prod_ff), cfg.rot2_sine, cfg.rot2_cosine);
      s3_z_in     = turn_b(s2_prod_ff);
      s3_prod_in  = products(s2_x_ff, turn_a(s2_prod_ff), cfg.rot3_sine, cfg.rot3_cosine);
      s4_rot_in.x_coord = turn_a(s3_prod_ff);
      s4_rot_in.y_coord = turn_b(s3_prod_ff);
      s4_rot_in.z_coord = s3_z_ff;
      s4_rot_in.color   = s3_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff  <= s1_prod_in;
      s1_y_ff     <= s1_y_in;
      s1_color_ff <= s1_color_in;
      s2_prod_ff  <= s2_prod_in;
      s2_x_ff     <= s2_x_in;
      s2_color_ff <= s1_color_ff;
      s3_prod_ff  <= s3_prod_in;
      s3_z_ff     <= s3_z_in;
      s3_color_ff <= s2_color_ff;
      s4_rot_ff   <= s4_rot_in;
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_rot   = s4_rot_ff;

endmodule

// File: design/pprp_project.sv
// ----------------------------------------------------------------------------
// pprp_project
// seven-stage perspective projection, dot size and screen clip
// ----------------------------------------------------------------------------
module pprp_project import pprp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rot_type in_rot,
   input  cfg_type cfg,
   output logic    out_valid,
   output dot_type out_dot
);

   localparam int LANES   = 2;
   localparam int NSTAGE  = 7;
   localparam int EXT_W   = COORD_W + 3;
   localparam int PX_W    = 2 * COORD_W + 1;
   localparam int MAG_W   = 2 * COORD_W - FRAC_BITS;
   localparam int RSHIFT  = MAG_W + 4;
   localparam int RECIP   = (1 << RSHIFT) / SCALE_DIV;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int RPROD_W = MAG_W + RECIP_W;
   localparam int CLIP_W  = PIX_W + 2;

   localparam logic signed [EXT_W-1:0] ONE_EXT  = EXT_W'(ONE);
   localparam logic signed [EXT_W-1:0] QROUND   = EXT_W'((1 << DEPTH_SH) - 1);
   localparam logic signed [EXT_W-1:0] FROUND   = EXT_W'(ONE - 1);
   localparam logic signed [EXT_W-1:0] SIZE_EXT = EXT_W'(SIZE_BASE);

   logic [NSTAGE-1:0]          valid_ff, valid_in;
   logic [DIM_W-1:0]           dim [LANES];
   logic [PIX_W-1:0]           size_ff [NSTAGE-1];
   logic [PIX_W-1:0]           color_ff [NSTAGE-1];
   logic [PIX_W-1:0]           a_size_in, a_depth_ff, a_depth_in;
   logic signed [COORD_W-1:0]  a_coord_ff [LANES];
   logic signed [PX_W-1:0]     b_prod_ff [LANES], b_prod_in [LANES];
   logic [MAG_W-1:0]           c_mag_ff [LANES], c_mag_in [LANES];
   logic [LANES-1:0]           c_neg_ff, c_neg_in;
   logic [RPROD_W-1:0]         d_rprod_ff [LANES], d_rprod_in [LANES];
   logic [MAG_W-1:0]           d_mag_ff [LANES];
   logic [LANES-1:0]           d_neg_ff;
   logic [MAG_W-1:0]           e_quot_ff [LANES], e_quot_in [LANES];
   logic [LANES-1:0]           e_fix_ff, e_fix_in, e_neg_ff;
   logic [PIX_W-1:0]           f_pos_ff [LANES], f_pos_in [LANES];
   logic                       pass_in;
   dot_type                    g_dot_ff, g_dot_in;

   assign dim[0] = cfg.screen_width;
   assign dim[1] = cfg.screen_height;

   // depth and dot size
   always_comb begin
      logic signed [EXT_W-1:0] zp, zq_adj, zq, depth_ext, sz2, sz_adj, szq, size_ext;
      zp        = EXT_W'(in_rot.z_coord) + ONE_EXT;
      zq_adj    = zp[EXT_W-1] ? zp + QROUND : zp;
      zq        = zq_adj >>> DEPTH_SH;
      depth_ext = ONE_EXT - zq;
      sz2       = zp <<< 1;
      sz_adj    = sz2[EXT_W-1] ? sz2 + FROUND : sz2;
      szq       = sz_adj >>> FRAC_BITS;
      size_ext  = SIZE_EXT - szq;
      a_depth_in = depth_ext[PIX_W-1:0];
      a_size_in  = size_ext[PIX_W-1:0];
   end

   // per-lane scaling: multiply, divide by one, divide by the scale constant
   always_comb begin
      logic signed [PX_W-1:0] abs_v;
      logic [MAG_W-1:0]       rem, quot;
      logic [PIX_W-1:0]       qlow, off;
      for (int l = 0; l < LANES; l++) begin
         b_prod_in[l]  = PX_W'(a_coord_ff[l]) * signed'(PX_W'(a_depth_ff));
         abs_v         = b_prod_ff[l][PX_W-1] ? -b_prod_ff[l] : b_prod_ff[l];
         c_mag_in[l]   = abs_v[FRAC_BITS +: MAG_W];
         c_neg_in[l]   = b_prod_ff[l][PX_W-1];
         d_rprod_in[l] = RPROD_W'(c_mag_ff[l]) * RPROD_W'(RECIP);
         e_quot_in[l]  = MAG_W'(d_rprod_ff[l] >> RSHIFT);
         rem           = d_mag_ff[l] - MAG_W'(e_quot_in[l] * SCALE_DIV);
         e_fix_in[l]   = (rem >= MAG_W'(SCALE_DIV));
         quot          = e_quot_ff[l] + MAG_W'(e_fix_ff[l]);
         qlow          = quot[PIX_W-1:0];
         off           = e_neg_ff[l] ? -qlow : qlow;
         f_pos_in[l]   = PIX_W'(dim[l] >> 1) + off;
      end
   end

   // clip against the screen less the dot size
   always_comb begin
      logic signed [CLIP_W-1:0] lim [LANES];
      logic [PIX_W-1:0]         size;
      size    = size_ff[NSTAGE-2];
      pass_in = (size != '0);
      for (int l = 0; l < LANES; l++) begin
         lim[l]  = signed'(CLIP_W'(dim[l])) - signed'(CLIP_W'(size));
         pass_in = pass_in && (f_pos_ff[l] > size) && (signed'(CLIP_W'(f_pos_ff[l])) < lim[l]);
      end
      g_dot_in.pos_x = f_pos_ff[0];
      g_dot_in.pos_y = f_pos_ff[1];
      g_dot_in.color = color_ff[NSTAGE-2];
      valid_in = {valid_ff[NSTAGE-2] & pass_in, valid_ff[NSTAGE-3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff[0]  <= a_size_in;
      color_ff[0] <= in_rot.color;
      for (int i = 1; i < NSTAGE - 1; i++) begin
         size_ff[i]  <= size_ff[i-1];
         color_ff[i] <= color_ff[i-1];
      end
      a_depth_ff    <= a_depth_in;
      a_coord_ff[0] <= in_rot.x_coord;
      a_coord_ff[1] <= in_rot.y_coord;
      b_prod_ff     <= b_prod_in;
      c_mag_ff      <= c_mag_in;
      c_neg_ff      <= c_neg_in;
      d_rprod_ff    <= d_rprod_in;
      d_mag_ff      <= c_mag_ff;
      d_neg_ff      <= c_neg_ff;
      e_quot_ff     <= e_quot_in;
      e_fix_ff      <= e_fix_in;
      e_neg_ff      <= d_neg_ff;
      f_pos_ff      <= f_pos_in;
      g_dot_ff      <= g_dot_in;
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_dot   = g_dot_ff;

endmodule

// File: design/pprp_plotter.sv
// ----------------------------------------------------------------------------
// pprp_plotter
// expands one dot into the four pixels of a 2x2 square, one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pprp_plotter import pprp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      dot_valid,
   input  dot_type   dot,
   output logic      rsp_valid,
   output pixel_type rsp_data
);

   logic                 active_ff, active_in;
   logic [DOT_CNT_W-1:0] cnt_ff, cnt_in;
   dot_type              base_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pixel_type            rsp_ff, rsp_in;

   always_comb begin
      logic [DOT_CNT_W-1:0] k;
      dot_type              src;
      k   = dot_valid ? '0 : cnt_ff;
      src = dot_valid ? dot : base_ff;
      rsp_in.pixel_x     = src.pos_x + PIX_W'(k[0]);
      rsp_in.pixel_y     = src.pos_y + PIX_W'(k[1]);
      rsp_in.pixel_color = src.color;
      rsp_in.last_pixel  = &k;
      cnt_in       = k + 1'b1;
      active_in    = dot_valid | (active_ff & ~(&cnt_ff));
      rsp_valid_in = dot_valid | active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dot_valid) begin
         base_ff <= dot;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_no_overrun, clock, reset, dot_valid, !active_ff, "dot arrived mid-square")
   `ASSERT_NEXT(a_square_whole, clock, reset, rsp_valid_ff && !rsp_ff.last_pixel, rsp_valid_ff, "square cut short")
   `ASSERT_IMPLY(a_last_count, clock, reset, active_ff, rsp_valid_ff && (rsp_ff.last_pixel == 1'b0), "last pixel before square ends")

endmodule

// File: design/point_rotate_project_plot_unit.sv
// ----------------------------------------------------------------------------
// point_rotate_project_plot_unit
// rotates a 3d point, projects it to the screen and plots a 2x2 dot
// ----------------------------------------------------------------------------
// A point transaction is taken on req_data at a rising edge with start high
// and busy low. After each accepted point busy is held high by a gap
// counter, so the next point waits until busy falls: the four pixel slots of
// the output port set that spacing.
// The first pixel of a point appears on rsp_data with rsp_valid high after the
// rotator, projection and plotter registers; the other three follow back to
// back, the fourth with last_pixel set. A point whose dot falls outside the
// screen, or whose size is zero or less, produces no pixels.
// The receiver cannot stall: each pixel is shown for exactly one cycle.
// Registers are written through csr_write_en, csr_index and csr_data. The user
// must write only while no point is in flight; the block does not enforce it.
// A synchronous reset empties the pipeline, clears busy and loads the
// default angles (no rotation) and a 480 by 272 screen.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_rotate_project_plot_unit import pprp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  point_type             req_data,
   output logic                  rsp_valid,
   output pixel_type             rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type            cfg_ff;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               accept;
   logic               rot_valid;
   rot_type            rot;
   logic               dot_valid;
   dot_type            dot;

   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_comb begin
      if (accept) begin
         gap_in = GAP_W'(ISSUE_GAP);
      end else if (busy) begin
         gap_in = gap_ff - 1'b1;
      end else begin
         gap_in = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot1_sine     <= RST_SINE;
         cfg_ff.rot1_cosine   <= RST_COSINE;
         cfg_ff.rot2_sine     <= RST_SINE;
         cfg_ff.rot2_cosine   <= RST_COSINE;
         cfg_ff.rot3_sine     <= RST_SINE;
         cfg_ff.rot3_cosine   <= RST_COSINE;
         cfg_ff.screen_width  <= RST_WIDTH;
         cfg_ff.screen_height <= RST_HEIGHT;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT1_SINE:     cfg_ff.rot1_sine     <= csr_data;
            CSR_ROT1_COSINE:   cfg_ff.rot1_cosine   <= csr_data;
            CSR_ROT2_SINE:     cfg_ff.rot2_sine     <= csr_data;
            CSR_ROT2_COSINE:   cfg_ff.rot2_cosine   <= csr_data;
            CSR_ROT3_SINE:     cfg_ff.rot3_sine     <= csr_data;
            CSR_ROT3_COSINE:   cfg_ff.rot3_cosine   <= csr_data;
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_data[DIM_W-1:0];
         endcase
      end
   end

   pprp_rotator u_rotator (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_point  (req_data),
      .cfg       (cfg_ff),
      .out_valid (rot_valid),
      .out_rot   (rot)
   );

   pprp_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_rot    (rot),
      .cfg       (cfg_ff),
      .out_valid (dot_valid),
      .out_dot   (dot)
   );

   pprp_plotter u_plotter (
      .clock     (clock),
      .reset     (reset),
      .dot_valid (dot_valid),
      .dot       (dot),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_issue_spacing, clock, reset, accept,
                busy ##1 busy ##1 busy ##1 !busy, "point spacing broken")

endmodule

// File: tb/sv/dot_plot_check_pkg.sv
// ----------------------------------------------------------------------------
// dot_plot_check_pkg
// Expected-pixel tracking for the point rotate, project and plot unit. Every
// accepted point is rotated, projected and clipped with the current register
// settings. A dot that passes queues its four pixels. Each pixel that the
// unit shows is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
package dot_plot_check_pkg;
   import pprp_pkg::*;

   class dot_plot_check;
      cfg_type     settings;
      pixel_type   pending_pixels[$];
      int unsigned errors;

      function new();
         settings.rot1_sine     = RST_SINE;
         settings.rot1_cosine   = RST_COSINE;
         settings.rot2_sine     = RST_SINE;
         settings.rot2_cosine   = RST_COSINE;
         settings.rot3_sine     = RST_SINE;
         settings.rot3_cosine   = RST_COSINE;
         settings.screen_width  = RST_WIDTH;
         settings.screen_height = RST_HEIGHT;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (csr_index_type'(index))
            CSR_ROT1_SINE:     settings.rot1_sine     = value;
            CSR_ROT1_COSINE:   settings.rot1_cosine   = value;
            CSR_ROT2_SINE:     settings.rot2_sine     = value;
            CSR_ROT2_COSINE:   settings.rot2_cosine   = value;
            CSR_ROT3_SINE:     settings.rot3_sine     = value;
            CSR_ROT3_COSINE:   settings.rot3_cosine   = value;
            CSR_SCREEN_WIDTH:  settings.screen_width  = value[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: settings.screen_height = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function longint wrap16(longint v);
         logic signed [COORD_W-1:0] t;
         t = v[COORD_W-1:0];
         return t;
      endfunction

      function longint low16(longint v);
         return v & 64'hFFFF;
      endfunction

      // planar rotation with truncating q12 scaling
      function void turn(inout longint a, inout longint b, input longint s, input longint c);
         longint na, nb;
         na = (a * c - b * s) / ONE;
         nb = (a * s + b * c) / ONE;
         a = wrap16(na);
         b = wrap16(nb);
      endfunction

      function void note_point(point_type p);
         longint    x, y, z, w, h, depth, px, py, size;
         pixel_type pix;
         x = p.x_coord;
         y = p.y_coord;
         z = p.z_coord;
         turn(x, z, settings.rot1_sine, settings.rot1_cosine);
         turn(y, z, settings.rot2_sine, settings.rot2_cosine);
         turn(x, y, settings.rot3_sine, settings.rot3_cosine);
         w = settings.screen_width;
         h = settings.screen_height;
         depth = low16(ONE - (z + ONE) / 4);
         px    = low16(w / 2 + (x * depth / ONE) / SCALE_DIV);
         py    = low16(h / 2 + (y * depth / ONE) / SCALE_DIV);
         size  = low16(SIZE_BASE - (z + ONE) * 2 / ONE);
         // clipped or empty dot
         if (size == 0 || px <= size || py <= size || px >= w - size || py >= h - size)
            return;
         for (int k = 0; k < DOT_PIXELS; k++) begin
            pix.pixel_x     = px[PIX_W-1:0] + k[0];
            pix.pixel_y     = py[PIX_W-1:0] + k[1];
            pix.pixel_color = {ALPHA, p.red[7:4], p.green[7:4], p.blue[7:4]};
            pix.last_pixel  = (k == DOT_PIXELS - 1);
            pending_pixels.push_back(pix);
         end
      endfunction

      task report(string what);
         $display("error: %s", what);
         errors++;
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel));
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x)
            report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
         if (got.pixel_color !== want.pixel_color)
            report($sformatf("pixel_color got %h want %h", got.pixel_color, want.pixel_color));
         if (got.last_pixel !== want.last_pixel)
            report($sformatf("last_pixel got %b want %b", got.last_pixel, want.last_pixel));
      endtask
   endclass

endpackage

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for point_rotate_project_plot_unit. A directed set of points
// covers coordinate extremes, size wrap, zero size and the screen edges,
// then random points run under several register settings, from plain turns
// to raw extreme sines and tiny or zero screens, with the sender idling at
// different rates. Pixels are checked against a model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
   import pprp_pkg::*;
   import dot_plot_check_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int QUIET_LIMIT  = 4000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   point_type             req_data;
   logic                  rsp_valid;
   pixel_type             rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   dot_plot_check board;
   int unsigned   accepted_points;
   int unsigned   quiet_cycles;

   point_rotate_project_plot_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // sample every transaction at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en)
            board.write_reg(csr_index, csr_data);
         if (start && !busy) begin
            board.note_point(req_data);
            accepted_points++;
         end
         if (rsp_valid)
            board.check_pixel(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [COORD_W-1:0] near_coord(int unsigned r);
      return 16'($urandom_range(2 * r) - r);
   endfunction

   function automatic point_type point_at(int x, int y, int z, logic [23:0] rgb);
      point_type p;
      p.x_coord = 16'(x);
      p.y_coord = 16'(y);
      p.z_coord = 16'(z);
      {p.red, p.green, p.blue} = rgb;
      return p;
   endfunction

   // mostly points near the origin so dots land on screen
   function automatic point_type random_point(int unsigned radius);
      point_type   p;
      int unsigned pick;
      int unsigned r;
      pick = $urandom_range(99);
      p = point_type'({$urandom, $urandom, $urandom});
      if (pick < 80) begin
         r = (pick < 60) ? radius : 4 * radius;
         p.x_coord = near_coord(r);
         p.y_coord = near_coord(r);
         p.z_coord = near_coord(r);
      end
      return p;
   endfunction

   function automatic void pick_angle(output logic signed [SIN_W-1:0] s,
                                      output logic signed [SIN_W-1:0] c);
      case ($urandom_range(9))
         0: begin s = 0;     c = 4096;  end
         1: begin s = 4096;  c = 0;     end
         2: begin s = 0;     c = -4096; end
         3: begin s = -4096; c = 0;     end
         4: begin s = 2896;  c = 2896;  end
         5: begin s = 2048;  c = 3547;  end
         6: begin s = -2048; c = 3547;  end
         7: begin s = 3547;  c = -2048; end
         8: begin s = -2896; c = -2896; end
         default: begin s = 1060; c = 3956; end
      endcase
   endfunction

   function automatic cfg_type table_settings(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      cfg_type c;
      pick_angle(c.rot1_sine, c.rot1_cosine);
      pick_angle(c.rot2_sine, c.rot2_cosine);
      pick_angle(c.rot3_sine, c.rot3_cosine);
      c.screen_width  = w;
      c.screen_height = h;
      return c;
   endfunction

   function automatic cfg_type plain_settings(logic signed [SIN_W-1:0] s1,
                                              logic signed [SIN_W-1:0] c1,
                                              logic signed [SIN_W-1:0] s2,
                                              logic signed [SIN_W-1:0] c2,
                                              logic signed [SIN_W-1:0] s3,
                                              logic signed [SIN_W-1:0] c3,
                                              logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      cfg_type c;
      c.rot1_sine   = s1;
      c.rot1_cosine = c1;
      c.rot2_sine   = s2;
      c.rot2_cosine = c2;
      c.rot3_sine   = s3;
      c.rot3_cosine = c3;
      c.screen_width  = w;
      c.screen_height = h;
      return c;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
   endtask

   task automatic load_settings(cfg_type c);
      write_reg(CSR_ROT1_SINE,     c.rot1_sine);
      write_reg(CSR_ROT1_COSINE,   c.rot1_cosine);
      write_reg(CSR_ROT2_SINE,     c.rot2_sine);
      write_reg(CSR_ROT2_COSINE,   c.rot2_cosine);
      write_reg(CSR_ROT3_SINE,     c.rot3_sine);
      write_reg(CSR_ROT3_COSINE,   c.rot3_cosine);
      // unused upper bits carry noise
      write_reg(CSR_SCREEN_WIDTH,  {4'($urandom_range(15)), c.screen_width});
      write_reg(CSR_SCREEN_HEIGHT, {4'($urandom_range(15)), c.screen_height});
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic idle_gap(int unsigned pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drive_point(point_type p);
      int unsigned seen;
      seen = accepted_points;
      start    <= 1'b1;
      req_data <= p;
      do
         @(negedge clock);
      while (accepted_points == seen);
   endtask

   task automatic send_points(int unsigned count, int unsigned pct, int unsigned radius);
      for (int unsigned n = 0; n < count; n++) begin
         idle_gap(pct);
         drive_point(random_point(radius));
      end
   endtask

   // no pixel pending and the pipeline drained of clipped points
   task automatic settle();
      start <= 1'b0;
      while (board.pending_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      board = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: origin, colors, wraps, zero size and screen edges
      drive_point(point_at(0, 0, 0, 24'hFF00FF));
      drive_point(point_at(0, 0, 0, 24'h00FF00));
      drive_point(point_at(0, 0, 0, 24'hAA55AA));
      drive_point(point_at(0, 0, 0, 24'h55AA55));
      drive_point(point_at(32767, 0, 0, 24'hFFFFFF));
      drive_point(point_at(-32768, -32768, -32768, 24'h000000));
      drive_point(point_at(0, 0, 32767, 24'h123456));
      drive_point(point_at(0, 0, -32768, 24'h89ABCD));
      drive_point(point_at(0, 0, 2047, 24'hF0F0F0));
      drive_point(point_at(0, 0, 2048, 24'h0F0F0F));
      drive_point(point_at(0, 0, -4097, 24'h808080));
      drive_point(point_at(-1, -1, -1, 24'h7F7F7F));
      drive_point(point_at(-7950, 0, 0, 24'h314159));
      drive_point(point_at(-7984, 0, 0, 24'h271828));
      drive_point(point_at(7950, 0, 0, 24'hC0FFEE));
      drive_point(point_at(7984, 0, 0, 24'hBEEF00));
      drive_point(point_at(0, 4470, 0, 24'h10E0A0));
      drive_point(point_at(0, 4500, 0, 24'hE01050));
      drive_point(point_at(0, -4470, 0, 24'h5A5A5A));
      drive_point(point_at(0, -4500, 0, 24'hA5A5A5));
      settle();

      load_settings(plain_settings(4096, 0, 0, -4096, -4096, 0, 1023, 1023));
      send_points(40, 0, 3000);
      settle();

      load_settings(table_settings(640, 480));
      send_points(40, 88, 3000);
      settle();

      load_settings(plain_settings(-8192, 8191, 8191, -8192, -8192, -8192, 1023, 64));
      send_points(25, 11, 3000);
      settle();

      load_settings(plain_settings(0, 4096, 0, 4096, 0, 4096, 0, 0));
      send_points(10, 0, 3000);
      settle();

      load_settings(table_settings(64, 64));
      send_points(40, 11, 800);
      settle();

      load_settings(cfg_type'({$urandom, $urandom, $urandom}));
      send_points(30, 0, 3000);
      settle();

      load_settings(table_settings(1023, 1023));
      send_points(40, 88, 6000);
      settle();

      load_settings(plain_settings(0, 4096, 0, 4096, 0, 4096, 480, 272));
      send_points(30, 11, 3000);
      settle();

      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
